/* hw/rtl/primality_test_32bit_core_macros.svh */
// ----------------------------------------------------------------------------
// primality_test_32bit_core_macros
// Assertion macros used by the checking code of the primality core.
// ----------------------------------------------------------------------------
`ifndef PRIMALITY_TEST_32BIT_CORE_MACROS_SVH
`define PRIMALITY_TEST_32BIT_CORE_MACROS_SVH

// Check that an implication holds at every clock edge outside reset.
`define PT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that an implication holds in the cycle after the antecedent.
`define PT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/pt32_pkg.sv */
// ----------------------------------------------------------------------------
// pt32_pkg
// Shared types and constants of the 32-bit primality test core.
// ----------------------------------------------------------------------------
package pt32_pkg;

  localparam int unsigned WordW = 32;

  // Classification handed from the front end to the back end.
  typedef enum logic [1:0] {
    CLS_COMPOSITE = 2'd0,
    CLS_PRIME     = 2'd1,
    CLS_TEST      = 2'd2
  } cls_e;

  typedef struct packed {
    cls_e             cls;
    logic [WordW-1:0] n;
  } job_t;

  localparam int unsigned JobW = $bits(job_t);

endpackage

/* hw/rtl/primality_test_32bit_core.sv */
// ----------------------------------------------------------------------------
// primality_test_32bit_core
// Stream in a 32-bit candidate, stream out one prime/not-prime bit.
// ----------------------------------------------------------------------------
// Input channel s_axis: tdata[31:0] carries the candidate. Output channel
// m_axis: tdata[0] is 1 when the candidate is prime, bits 7:1 are zero.
// One result comes out per candidate, in order.
// The classifier does trial division by the primes 2..31, one nibble a
// cycle (candidates below 40 are looked up in a table instead), and stops
// at the first divisor found. Every candidate then goes to the Miller-Rabin
// engine through a two-entry queue; the engine tests only the survivors, so
// classification of the next candidate overlaps the test of this one. Each
// modular multiply runs in the shared reducer, one remainder bit a cycle, and
// a full test needs up to about 200 multiplies, composites usually fewer.
// Reset clears all control state; no result is pending afterwards.
// When m_axis_tready is low the result is held and the engine waits; the
// queue then fills and s_axis_tready falls.
// ----------------------------------------------------------------------------
`include "primality_test_32bit_core_macros.svh"
module primality_test_32bit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] candidate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [0] is_prime, [7:1] zero
);
  import pt32_pkg::*;

  logic f_valid, f_ready, q_valid, q_ready, res;
  job_t f_job, q_job;

  pt32_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cand_i(s_axis_tdata), .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  pt32_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_job),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_job)
  );

  pt32_back u_back (
    .clk_i, .rst_ni, .job_valid_i(q_valid), .job_ready_o(q_ready), .job_i(q_job),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {7'd0, res};

  `PT_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata))
  `PT_ASSERT_IMP(a_pad, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[7:1] == 7'd0)

endmodule

/* hw/rtl/pt32_front.sv */
// ----------------------------------------------------------------------------
// pt32_front
// Accepts candidates and classifies them by the small-prime table and
// trial division by the primes up to 31.
// ----------------------------------------------------------------------------
module pt32_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [31:0]               cand_i,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output pt32_pkg::job_t            job_o
);
  import pt32_pkg::*;

  logic        busy_q, busy_d;
  logic [31:0] n_q, n_d;
  logic [3:0]  idx_q, idx_d;
  logic        comp_q, comp_d;
  logic [5:0]  p_cur;
  logic [15:0] recip;
  logic        is_small_prime;

  // Trial divisor sequence: 2, 3, 5, ..., 31, with ceil(2^16/p) beside it.
  always_comb begin
    case (idx_q)
      4'd0: begin p_cur = 6'd2;  recip = 16'd32768; end
      4'd1: begin p_cur = 6'd3;  recip = 16'd21846; end
      4'd2: begin p_cur = 6'd5;  recip = 16'd13108; end
      4'd3: begin p_cur = 6'd7;  recip = 16'd9363;  end
      4'd4: begin p_cur = 6'd11; recip = 16'd5958;  end
      4'd5: begin p_cur = 6'd13; recip = 16'd5042;  end
      4'd6: begin p_cur = 6'd17; recip = 16'd3856;  end
      4'd7: begin p_cur = 6'd19; recip = 16'd3450;  end
      4'd8: begin p_cur = 6'd23; recip = 16'd2850;  end
      4'd9: begin p_cur = 6'd29; recip = 16'd2260;  end
      default: begin p_cur = 6'd31; recip = 16'd2115; end
    endcase
  end

  always_comb begin
    case (n_q[5:0])
      6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31,
      6'd37: is_small_prime = 1'b1;
      default: is_small_prime = 1'b0;
    endcase
  end

  // Remainder one nibble a cycle, most significant first: 8 steps per divisor.
  // The partial value stays below 512, so the reciprocal quotient is exact.
  logic [2:0]  bit_q, bit_d;
  logic [4:0]  nib_lo;
  logic [9:0]  r_try;
  logic [25:0] q_prod;
  logic [9:0]  q_est;
  logic [5:0]  r_q, r_d;

  assign in_ready_o = !busy_q;
  assign nib_lo = 5'd28 - {bit_q, 2'b00};

  always_comb begin
    busy_d = busy_q;
    n_d    = n_q;
    idx_d  = idx_q;
    comp_d = comp_q;
    bit_d  = bit_q;
    r_d    = r_q;
    job_valid_o = 1'b0;
    job_o.n   = n_q;
    job_o.cls = CLS_TEST;
    r_try  = {r_q, n_q[nib_lo +: 4]};
    q_prod = {16'd0, r_try} * {10'd0, recip};
    q_est  = q_prod[25:16];
    if (!busy_q) begin
      if (in_valid_i) begin
        busy_d = 1'b1;
        n_d    = cand_i;
        idx_d  = '0;
        bit_d  = '0;
        r_d    = '0;
        comp_d = 1'b0;
      end
    end else if (n_q < 32'd40 || comp_q || idx_q == 4'd11) begin
      job_valid_o = 1'b1;
      if (n_q < 32'd40) job_o.cls = is_small_prime ? CLS_PRIME : CLS_COMPOSITE;
      else if (comp_q) job_o.cls = CLS_COMPOSITE;
      if (job_ready_i) busy_d = 1'b0;
    end else begin
      r_d = 6'(r_try - q_est * {4'd0, p_cur});
      bit_d = bit_q + 3'd1;
      if (bit_q == 3'd7) begin
        if (r_d == 6'd0) comp_d = 1'b1;
        idx_d = idx_q + 4'd1;
        bit_d = '0;
        r_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    idx_q  <= idx_d;
    comp_q <= comp_d;
    bit_q  <= bit_d;
    r_q    <= r_d;
  end

endmodule

/* hw/rtl/pt32_queue.sv */
// ----------------------------------------------------------------------------
// pt32_queue
// Two-entry queue between the classifier and the Miller-Rabin engine.
// ----------------------------------------------------------------------------
module pt32_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  pt32_pkg::job_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output pt32_pkg::job_t rd_data_o
);
  import pt32_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr_en = wr_valid_i && wr_ready_o;
  assign rd_en = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wp_q <= !wp_q;
      if (rd_en) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wp_q] <= wr_data_i;
  end

endmodule

/* hw/rtl/pt32_mulmod.sv */
// ----------------------------------------------------------------------------
// pt32_mulmod
// Modular multiply: one 32x32 product, then a restoring reduction of the
// 64-bit product, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pt32_mulmod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] m_i,
  output logic        done_o,
  output logic [31:0] r_o
);
  logic        run_q;
  logic [63:0] prod_q;
  logic [32:0] rem_q;
  logic [6:0]  cnt_q;
  logic [32:0] sh;

  assign sh = {rem_q[31:0], prod_q[63]};
  assign r_o = rem_q[31:0];
  assign done_o = run_q && cnt_q == 7'd64;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (start_i) begin
      run_q <= 1'b1;
    end else if (done_o) begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= 64'(a_i) * 64'(b_i);
      rem_q  <= '0;
      cnt_q  <= '0;
    end else if (run_q && cnt_q != 7'd64) begin
      prod_q <= {prod_q[62:0], 1'b0};
      rem_q  <= (sh >= {1'b0, m_i}) ? sh - {1'b0, m_i} : sh;
      cnt_q  <= cnt_q + 7'd1;
    end
  end

endmodule

/* hw/rtl/pt32_back.sv */
// ----------------------------------------------------------------------------
// pt32_back
// Miller-Rabin engine for witnesses 2, 7 and 61 plus the result register.
// ----------------------------------------------------------------------------
module pt32_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  pt32_pkg::job_t job_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output logic           res_o
);
  import pt32_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_SQR = 3'd1, S_MUL = 3'd2,
                         S_CHK = 3'd3, S_LOOP = 3'd4, S_WAIT = 3'd5, S_OUT = 3'd6;

  logic [2:0]  st_q;
  logic [31:0] n_q, d_q, x_q, base_q;
  logic [4:0]  r_q, j_q, bit_q;
  logic [1:0]  w_q;
  logic        res_q, ov_q;
  logic        mm_start, mm_done;
  logic [31:0] mm_a, mm_b, mm_r;
  logic [31:0] nm1;
  logic [31:0] jn_m1;
  logic [31:0] dsh;
  logic [4:0]  tz;

  assign nm1 = n_q - 32'd1;
  assign job_ready_o = st_q == S_IDLE && !ov_q;
  assign res_valid_o = ov_q;
  assign res_o = res_q;

  // Odd part of n-1: count trailing zeros of n-1.
  always_comb begin
    jn_m1 = job_i.n - 32'd1;
    tz = '0;
    for (int i = 31; i >= 0; i--) if (jn_m1[i]) tz = 5'(i);
    dsh = jn_m1 >> tz;
  end

  pt32_mulmod u_mm (
    .clk_i, .rst_ni, .start_i(mm_start), .a_i(mm_a), .b_i(mm_b), .m_i(n_q),
    .done_o(mm_done), .r_o(mm_r)
  );

  assign mm_a = x_q;
  assign mm_b = (st_q == S_MUL) ? base_q : x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
      mm_start <= 1'b0;
    end else begin
      if (ov_q && res_ready_i) ov_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          mm_start <= job_valid_i && !ov_q && job_i.cls == CLS_TEST;
          if (job_valid_i && !ov_q) begin
            n_q <= job_i.n;
            if (job_i.cls != CLS_TEST) begin
              res_q <= job_i.cls == CLS_PRIME;
              ov_q  <= 1'b1;
            end else begin
              d_q <= dsh; r_q <= tz; w_q <= 2'd0;
              base_q <= 32'd2; x_q <= 32'd1; bit_q <= 5'd31;
              st_q <= S_SQR;
            end
          end
        end
        S_SQR: begin
          mm_start <= mm_done && (d_q[bit_q] || bit_q != 5'd0);
          if (mm_done) begin
            x_q <= mm_r;
            if (d_q[bit_q]) st_q <= S_MUL;
            else if (bit_q == 5'd0) st_q <= S_CHK;
            else bit_q <= bit_q - 5'd1;
          end
        end
        S_MUL: begin
          mm_start <= mm_done && bit_q != 5'd0;
          if (mm_done) begin
            x_q <= mm_r;
            if (bit_q == 5'd0) st_q <= S_CHK;
            else begin bit_q <= bit_q - 5'd1; st_q <= S_SQR; end
          end
        end
        S_CHK: begin
          j_q <= 5'd0;
          mm_start <= !(x_q == 32'd1 || x_q == nm1 || n_q == 32'd61) && r_q != 5'd0;
          if (x_q == 32'd1 || x_q == nm1 || n_q == 32'd61) st_q <= S_WAIT;
          else if (r_q == 5'd0) begin res_q <= 1'b0; ov_q <= 1'b1; st_q <= S_OUT; end
          else st_q <= S_LOOP;
        end
        S_LOOP: begin
          mm_start <= mm_done && mm_r != nm1 && j_q + 5'd1 != r_q;
          if (mm_done) begin
            x_q <= mm_r;
            j_q <= j_q + 5'd1;
            if (mm_r == nm1) st_q <= S_WAIT;
            else if (j_q + 5'd1 == r_q) begin
              res_q <= 1'b0; ov_q <= 1'b1; st_q <= S_OUT;
            end
          end
        end
        S_WAIT: begin
          mm_start <= w_q != 2'd2;
          if (w_q == 2'd2) begin res_q <= 1'b1; ov_q <= 1'b1; st_q <= S_OUT; end
          else begin
            w_q <= w_q + 2'd1;
            base_q <= (w_q == 2'd0) ? 32'd7 : 32'd61;
            x_q <= 32'd1; bit_q <= 5'd31; st_q <= S_SQR;
          end
        end
        S_OUT: begin
          mm_start <= 1'b0;
          st_q <= S_IDLE;
        end
        default: begin
          mm_start <= 1'b0;
          st_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Feeds 32-bit candidates into the primality core and checks every answer
// against a Miller-Rabin predictor computed in the bench, with random idle
// cycles on both stream channels.
// ----------------------------------------------------------------------------
module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] candidate
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [0] is_prime, [7:1] zero

  logic [31:0] candidates_q[$];
  logic        verdicts_q[$];
  int unsigned errors;
  int unsigned cycles;
  bit          calm;

  primality_test_32bit_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [31:0] mulmod(logic [31:0] a, logic [31:0] b, logic [31:0] m);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return 32'(p % {32'd0, m});
  endfunction

  function automatic logic [31:0] powmod(logic [31:0] b, logic [31:0] e, logic [31:0] m);
    logic [31:0] acc;
    acc = 32'd1 % m;
    for (int k = 31; k >= 0; k--) begin
      acc = mulmod(acc, acc, m);
      if (e[k]) acc = mulmod(acc, b, m);
    end
    return acc;
  endfunction

  function automatic logic primality(logic [31:0] n);
    logic [31:0] d, x, a;
    int unsigned r;
    int unsigned wits[3] = '{2, 7, 61};
    int unsigned divs[11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
    bit ok;
    if (n < 40) begin
      return n inside {2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    end
    foreach (divs[i]) if (n % divs[i] == 0) return 1'b0;
    d = n - 1;
    r = 0;
    while (!d[0]) begin
      d = d >> 1;
      r++;
    end
    foreach (wits[i]) begin
      a = wits[i] % n;
      // a witness that is a multiple of the candidate proves nothing
      if (a == 0) continue;
      x = powmod(a, d, n);
      if (x == 1 || x == n - 1) continue;
      ok = 0;
      for (int j = 0; j < r; j++) begin
        x = mulmod(x, x, n);
        if (x == n - 1) begin
          ok = 1;
          break;
        end
      end
      if (!ok) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // driver: hold the transaction until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (candidates_q.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= candidates_q[0];
        verdicts_q = {verdicts_q, primality(candidates_q[0])};
        candidates_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      cycles        <= 0;
    end else begin
      cycles <= cycles + 1;
      m_axis_tready <= calm || $urandom_range(99) >= 24;
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_q.size() == 0) begin
          report($sformatf("unexpected result %h", m_axis_tdata));
        end else begin
          if (m_axis_tdata[0] !== verdicts_q[0])
            report($sformatf("is_prime %b, want %b", m_axis_tdata[0], verdicts_q[0]));
          if (m_axis_tdata[7:1] !== 7'd0)
            report($sformatf("pad bits %h not zero", m_axis_tdata[7:1]));
          verdicts_q.pop_front();
        end
      end
    end
  end

  initial begin
    logic [31:0] v;
    int unsigned pick;
    logic [31:0] directed[] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd37, 32'd39, 32'd40, 32'd41,
      32'd61, 32'd49, 32'd961, 32'd1369, 32'd2047, 32'd3215031751, 32'd4294967291,
      32'd4294967295, 32'd4294967294, 32'd2147483647, 32'd2147483648, 32'd65537,
      32'd25326001, 32'd1373653, 32'd4294836225, 32'd7, 32'd341};
    errors = 0;
    calm = 0;
    rst_ni = 1'b0;
    foreach (directed[i]) candidates_q = {candidates_q, directed[i]};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 80; i++) begin
      pick = $urandom_range(3);
      v = $urandom;
      if (pick == 0) v = $urandom_range(120);
      else if (pick == 1) v = v | 32'd1;
      candidates_q = {candidates_q, v};
      if (i == 40) begin
        wait (candidates_q.size() < 5);
        calm = 1;
      end
      if (i == 70) begin
        // keep both sides busy until the stretch has drained
        wait (candidates_q.size() < 5);
        calm = 0;
      end
    end
    wait (candidates_q.size() == 0 && verdicts_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("** primality_test_32bit_core: PASSED **");
    else $display("** primality_test_32bit_core: FAILED **");
    $finish;
  end

  // generous limit for 105 items at their worst, stalls included
  initial begin
    wait (cycles >= 8000000);
    $display("** primality_test_32bit_core: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/pt32_pkg.sv
hw/rtl/pt32_front.sv
hw/rtl/pt32_queue.sv
hw/rtl/pt32_mulmod.sv
hw/rtl/pt32_back.sv
hw/rtl/primality_test_32bit_core.sv
bench/testbench.sv
